>>> src/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent checks for same-cycle and next-cycle implications, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

`define TCW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("text console writer check failed");

`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("text console writer check failed");

`else

`define TCW_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> src/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, request codes, screen defaults and controller/datapath types.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int SCREEN_ROWS_DEF    = 25;
	localparam int SCREEN_COLUMNS_DEF = 80;

	localparam int REQ_W   = 3;
	localparam int GLYPH_W = 8;
	localparam int ATTR_W  = 8;
	localparam int POS_W   = 11;

	localparam logic [REQ_W-1:0] REQ_SHOW_ATTR = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SHOW_DEF  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SET_CUR   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ      = 3'd4;

	localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 8'h20;
	localparam logic [ATTR_W-1:0]  RESET_ATTR  = 8'h07;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_INIT_STEP,
		OP_CLEAR_START,
		OP_CLEAR_STEP,
		OP_COPY_START,
		OP_COPY_STEP,
		OP_FILL_STEP,
		OP_PUT,
		OP_SET_CUR,
		OP_READ,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic             cur_full;
		logic             copy_end;
		logic             ptr_at_end;
	} sts_t;

endpackage

>>> src/tcw_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one console request.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [GLYPH_W-1:0] glyph;
	logic [ATTR_W-1:0]  cell_attr;
	logic [POS_W-1:0]   new_position;
	logic [POS_W-1:0]   cell_index;

	modport source (
		output valid, req_type, glyph, cell_attr, new_position, cell_index,
		input  ready
	);

	modport sink (
		input  valid, req_type, glyph, cell_attr, new_position, cell_index,
		output ready
	);

endinterface

>>> src/tcw_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one console result.
// ----------------------------------------------------------------------------
interface tcw_rsp_if import tcw_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [POS_W-1:0]   cursor_pos;
	logic [GLYPH_W-1:0] read_glyph;
	logic [ATTR_W-1:0]  read_attr;
	logic               scrolled;

	modport source (
		output valid, cursor_pos, read_glyph, read_attr, scrolled,
		input  ready
	);

	modport sink (
		input  valid, cursor_pos, read_glyph, read_attr, scrolled,
		output ready
	);

endinterface

>>> src/text_console_writer.sv
`timescale 1ns / 1ps
// Set cursor, read cell, unknown requests and a show without scroll go from decode straight
// to the result; a clear first blanks all ROWS*COLUMNS cells in one sweep.
// A show at a full screen scrolls: a copy pass over (ROWS-1)*COLUMNS cells, a fill pass over
// COLUMNS cells, then the put; the sweep over the cell memory moves one cell per cycle.
// The request port stays low while a request is in work, until its result is loaded.
// After reset a pass over all ROWS*COLUMNS cells blanks the memory.
// ----------------------------------------------------------------------------
// Text console writer
// Text screen buffer with cursor, clear, scroll and cell read-back.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
	parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF,
	parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [ATTR_W-1:0] cfg_wr_data,
	tcw_req_if.sink           req,
	tcw_rsp_if.source         rsp
);

	cmd_t cmd;
	sts_t sts;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcw_datapath #(
		.SCREEN_ROWS    (SCREEN_ROWS),
		.SCREEN_COLUMNS (SCREEN_COLUMNS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.req_type     (req.req_type),
		.glyph        (req.glyph),
		.cell_attr    (req.cell_attr),
		.new_position (req.new_position),
		.cell_index   (req.cell_index),
		.cursor_pos   (rsp.cursor_pos),
		.read_glyph   (rsp.read_glyph),
		.read_attr    (rsp.read_attr),
		.scrolled     (rsp.scrolled)
	);

endmodule

>>> src/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences the clearing pass, scroll copy and fill, cell writes and results.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_ctrl import tcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_FILL,
		ST_PUT,
		ST_CLEAR,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   is_show;
	logic   rsp_load;

	assign out_free  = !out_valid_q || out_ready;
	assign is_show   = (sts.req_type == REQ_SHOW_ATTR) || (sts.req_type == REQ_SHOW_DEF);
	assign rsp_load  = (state_q == ST_DONE) && out_free;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= rsp_load || (out_valid_q && !out_ready);
			case (state_q)
				ST_INIT: begin
					if (sts.ptr_at_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (is_show) begin
						state_q <= sts.cur_full ? ST_COPY : ST_DONE;
					end else if (sts.req_type == REQ_CLEAR) begin
						state_q <= ST_CLEAR;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_COPY: begin
					if (sts.copy_end) begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (sts.ptr_at_end) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					state_q <= ST_DONE;
				end
				ST_CLEAR: begin
					if (sts.ptr_at_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold the result until the output register frees up
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.op = OP_NONE;
		case (state_q)
			ST_INIT:  cmd.op = OP_INIT_STEP;
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_CAPTURE;
				end
			end
			ST_EXEC: begin
				if (is_show) begin
					cmd.op = sts.cur_full ? OP_COPY_START : OP_PUT;
				end else begin
					case (sts.req_type)
						REQ_CLEAR:   cmd.op = OP_CLEAR_START;
						REQ_SET_CUR: cmd.op = OP_SET_CUR;
						REQ_READ:    cmd.op = OP_READ;
						default:     cmd.op = OP_NONE;
					endcase
				end
			end
			ST_COPY:  cmd.op = OP_COPY_STEP;
			ST_FILL:  cmd.op = OP_FILL_STEP;
			ST_PUT:   cmd.op = OP_PUT;
			ST_CLEAR: cmd.op = OP_CLEAR_STEP;
			ST_DONE: begin
				if (out_free) begin
					cmd.op = OP_RESULT;
				end
			end
			default:  cmd.op = OP_NONE;
		endcase
	end

	`TCW_ASSERT_NEXT(a_accept_exec, clk, arst_n, state_q == ST_IDLE && in_valid, state_q == ST_EXEC)
	`TCW_ASSERT_NEXT(a_result_load, clk, arst_n, rsp_load, out_valid_q && state_q == ST_IDLE)
	`TCW_ASSERT_NEXT(a_fill_put, clk, arst_n, state_q == ST_FILL, state_q == ST_FILL || state_q == ST_PUT)

endmodule

>>> src/tcw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer datapath
// Cell memory, cursor, sweep pointer, request capture and result register.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_datapath import tcw_pkg::*; #(
	parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF,
	parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_wr_en,
	input  logic [ATTR_W-1:0]  cfg_wr_data,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [GLYPH_W-1:0] glyph,
	input  logic [ATTR_W-1:0]  cell_attr,
	input  logic [POS_W-1:0]   new_position,
	input  logic [POS_W-1:0]   cell_index,
	output logic [POS_W-1:0]   cursor_pos,
	output logic [GLYPH_W-1:0] read_glyph,
	output logic [ATTR_W-1:0]  read_attr,
	output logic               scrolled
);

	localparam int CELLS  = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int LAST   = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CUR_W  = $clog2(CELLS + 1);
	localparam int CMP_W  = (CUR_W > POS_W) ? CUR_W : POS_W;
	localparam int CELL_W = ATTR_W + GLYPH_W;

	logic [CELL_W-1:0]  mem [CELLS];
	logic [CELL_W-1:0]  rd_q;

	logic [REQ_W-1:0]   req_q;
	logic [GLYPH_W-1:0] glyph_q;
	logic [ATTR_W-1:0]  attr_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   idx_q;

	logic [CUR_W-1:0]   cursor_q;
	logic [ADDR_W-1:0]  ptr_q;
	logic               scrolled_q;
	logic [ATTR_W-1:0]  dattr_q;

	logic [POS_W-1:0]   cursor_pos_q;
	logic [GLYPH_W-1:0] read_glyph_q;
	logic [ATTR_W-1:0]  read_attr_q;
	logic               scrolled_out_q;

	logic               we;
	logic [ADDR_W-1:0]  wa;
	logic [CELL_W-1:0]  wd;
	logic               re;
	logic [ADDR_W-1:0]  ra;
	logic               idx_in_range;
	logic               copy_end;
	logic               ptr_at_end;
	logic [CUR_W-1:0]   set_value;

	assign idx_in_range = CMP_W'(idx_q) < CMP_W'(CELLS);
	assign copy_end     = (ptr_q == ADDR_W'(LAST - 1));
	assign ptr_at_end   = (ptr_q == ADDR_W'(CELLS - 1));
	assign set_value    = (CMP_W'(pos_q) > CMP_W'(CELLS)) ? CUR_W'(CELLS) : CUR_W'(pos_q);

	assign sts.req_type   = req_q;
	assign sts.cur_full   = (cursor_q == CUR_W'(CELLS));
	assign sts.copy_end   = copy_end;
	assign sts.ptr_at_end = ptr_at_end;

	always_comb begin
		we = 1'b0;
		wa = ptr_q;
		wd = {dattr_q, BLANK_GLYPH};
		re = 1'b0;
		ra = ptr_q + ADDR_W'(SCREEN_COLUMNS + 1);
		case (cmd.op)
			OP_INIT_STEP: begin
				we = 1'b1;
				wd = {RESET_ATTR, BLANK_GLYPH};
			end
			OP_CLEAR_STEP, OP_FILL_STEP: begin
				we = 1'b1;
			end
			OP_COPY_START: begin
				re = 1'b1;
				ra = ADDR_W'(SCREEN_COLUMNS);
			end
			OP_COPY_STEP: begin
				// write the row below, fetch the next source cell
				we = 1'b1;
				wd = rd_q;
				re = !copy_end;
			end
			OP_PUT: begin
				we = 1'b1;
				wa = cursor_q[ADDR_W-1:0];
				wd = {attr_q, glyph_q};
			end
			OP_READ: begin
				re = idx_in_range;
				ra = ADDR_W'(idx_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAPTURE) begin
			req_q   <= req_type;
			glyph_q <= glyph;
			attr_q  <= (req_type == REQ_SHOW_DEF) ? dattr_q : cell_attr;
			pos_q   <= new_position;
			idx_q   <= cell_index;
		end
		if (cmd.op == OP_RESULT) begin
			cursor_pos_q   <= POS_W'(cursor_q);
			scrolled_out_q <= scrolled_q;
			if (req_q == REQ_READ && idx_in_range) begin
				read_glyph_q <= rd_q[GLYPH_W-1:0];
				read_attr_q  <= rd_q[CELL_W-1:GLYPH_W];
			end else begin
				read_glyph_q <= '0;
				read_attr_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q   <= '0;
			ptr_q      <= '0;
			scrolled_q <= 1'b0;
			dattr_q    <= RESET_ATTR;
		end else begin
			if (cfg_wr_en) begin
				dattr_q <= cfg_wr_data;
			end
			case (cmd.op)
				OP_CAPTURE: begin
					scrolled_q <= 1'b0;
				end
				OP_INIT_STEP, OP_CLEAR_STEP, OP_COPY_STEP, OP_FILL_STEP: begin
					ptr_q <= ptr_q + ADDR_W'(1);
				end
				OP_CLEAR_START: begin
					ptr_q    <= '0;
					cursor_q <= '0;
				end
				OP_COPY_START: begin
					ptr_q      <= '0;
					cursor_q   <= CUR_W'(LAST);
					scrolled_q <= 1'b1;
				end
				OP_PUT: begin
					cursor_q <= cursor_q + CUR_W'(1);
				end
				OP_SET_CUR: begin
					cursor_q <= set_value;
				end
				default: begin
					ptr_q <= ptr_q;
				end
			endcase
		end
	end

	assign cursor_pos = cursor_pos_q;
	assign read_glyph = read_glyph_q;
	assign read_attr  = read_attr_q;
	assign scrolled   = scrolled_out_q;

	`TCW_ASSERT_NOW(a_cursor_bound, clk, arst_n, 1'b1, cursor_q <= CUR_W'(CELLS))
	`TCW_ASSERT_NOW(a_put_in_screen, clk, arst_n, cmd.op == OP_PUT, cursor_q < CUR_W'(CELLS))
	`TCW_ASSERT_NOW(a_copy_in_range, clk, arst_n, cmd.op == OP_COPY_STEP, ptr_q < ADDR_W'(LAST))

endmodule
